// ===== hdl/acfp_pkg.sv =====
// Package with the shared types and constants of the ASCII command frame parser.
package acfp_pkg;

	localparam int unsigned NumRegs = 5;
	localparam int unsigned AddrWidth = 5;
	localparam int unsigned DataWidth = 32;

	localparam logic [2:0] REG_LIGHT_ON = 3'd0;
	localparam logic [2:0] REG_LIGHT_OFF = 3'd1;
	localparam logic [2:0] REG_SET_COLOR = 3'd2;
	localparam logic [2:0] REG_READ_TIME = 3'd3;
	localparam logic [2:0] REG_SYS_RESET = 3'd4;

	localparam logic [7:0] RST_LIGHT_ON = 8'd49;
	localparam logic [7:0] RST_LIGHT_OFF = 8'd50;
	localparam logic [7:0] RST_SET_COLOR = 8'd51;
	localparam logic [7:0] RST_READ_TIME = 8'd52;
	localparam logic [7:0] RST_SYS_RESET = 8'd53;

	localparam logic [2:0] PH_CMD = 3'd0;
	localparam logic [2:0] PH_LEN = 3'd1;
	localparam logic [2:0] PH_DATA = 3'd2;
	localparam logic [2:0] PH_CK1 = 3'd3;
	localparam logic [2:0] PH_CK2 = 3'd4;

	localparam logic [7:0] ASCII_ZERO = 8'h30;
	localparam logic [7:0] ASCII_ONE = 8'h31;

	typedef struct packed {
		logic [7:0] light_on;
		logic [7:0] light_off;
		logic [7:0] set_color;
		logic [7:0] read_time;
		logic [7:0] sys_reset;
	} codes_t;

	typedef struct packed {
		logic [7:0] echo_byte;
		logic frame_done;
		logic checksum_ok;
		logic [7:0] command_code;
		logic [7:0] data_count;
		logic [31:0] decimal_value;
	} result_t;

endpackage

// ===== hdl/ascii_command_frame_parser_top.sv =====
// Top level of the ASCII command frame parser: input and result registers around the core.
//
// Each received byte is one input transaction and gives exactly one result transaction,
// carrying its echo byte; the byte that ends a frame also carries the command, data count,
// decimal value and checksum flag. A byte is held in the input register (rx_s1), and the
// frame state is updated as it moves into the result register (result_s2), which holds it
// while out_ready is low; one byte per cycle is sustained while out_ready stays high.
// Command codes are written through the APB-style port; the user must write them only while
// the block is idle, which the block itself does not enforce.
module ascii_command_frame_parser_top (
	input  logic clk,
	input  logic arst_n,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [acfp_pkg::AddrWidth-1:0] paddr,
	input  logic [acfp_pkg::DataWidth-1:0] pwdata,
	output logic [acfp_pkg::DataWidth-1:0] prdata,
	output logic pready,
	input  logic in_valid,
	output logic in_ready,
	input  logic [7:0] rx_byte,
	output logic out_valid,
	input  logic out_ready,
	output logic [7:0] echo_byte,
	output logic frame_done,
	output logic checksum_ok,
	output logic [7:0] command_code,
	output logic [7:0] data_count,
	output logic [31:0] decimal_value
);

	acfp_pkg::codes_t codes;
	acfp_pkg::result_t result;
	acfp_pkg::result_t result_s2;
	logic [7:0] rx_s1;
	logic valid_s1;
	logic valid_s2;
	logic advance;

	assign advance = valid_s1 & (~valid_s2 | out_ready);
	assign in_ready = ~valid_s1 | advance;

	acfp_cfg_regs u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.codes(codes)
	);

	acfp_parse_core u_core (
		.clk(clk),
		.arst_n(arst_n),
		.step_en(advance),
		.rx_byte(rx_s1),
		.codes(codes),
		.result(result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (out_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready & in_valid) begin
			rx_s1 <= rx_byte;
		end
		if (advance) begin
			result_s2 <= result;
		end
	end

	assign out_valid = valid_s2;
	assign echo_byte = result_s2.echo_byte;
	assign frame_done = result_s2.frame_done;
	assign checksum_ok = result_s2.checksum_ok;
	assign command_code = result_s2.command_code;
	assign data_count = result_s2.data_count;
	assign decimal_value = result_s2.decimal_value;

endmodule

// ===== hdl/acfp_cfg_regs.sv =====
// Configuration register bank with its APB-style access port.
module acfp_cfg_regs (
	input  logic clk,
	input  logic arst_n,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [acfp_pkg::AddrWidth-1:0] paddr,
	input  logic [acfp_pkg::DataWidth-1:0] pwdata,
	output logic [acfp_pkg::DataWidth-1:0] prdata,
	output logic pready,
	output acfp_pkg::codes_t codes
);

	logic [2:0] reg_index;
	logic wr_en;
	acfp_pkg::codes_t codes_q;

	assign reg_index = paddr[acfp_pkg::AddrWidth-1:2];
	assign pready = 1'b1;
	assign wr_en = psel & penable & pwrite;
	assign codes = codes_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			codes_q.light_on <= acfp_pkg::RST_LIGHT_ON;
			codes_q.light_off <= acfp_pkg::RST_LIGHT_OFF;
			codes_q.set_color <= acfp_pkg::RST_SET_COLOR;
			codes_q.read_time <= acfp_pkg::RST_READ_TIME;
			codes_q.sys_reset <= acfp_pkg::RST_SYS_RESET;
		end else if (wr_en) begin
			unique case (reg_index)
				acfp_pkg::REG_LIGHT_ON: codes_q.light_on <= pwdata[7:0];
				acfp_pkg::REG_LIGHT_OFF: codes_q.light_off <= pwdata[7:0];
				acfp_pkg::REG_SET_COLOR: codes_q.set_color <= pwdata[7:0];
				acfp_pkg::REG_READ_TIME: codes_q.read_time <= pwdata[7:0];
				acfp_pkg::REG_SYS_RESET: codes_q.sys_reset <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_index)
			acfp_pkg::REG_LIGHT_ON: prdata = {24'd0, codes_q.light_on};
			acfp_pkg::REG_LIGHT_OFF: prdata = {24'd0, codes_q.light_off};
			acfp_pkg::REG_SET_COLOR: prdata = {24'd0, codes_q.set_color};
			acfp_pkg::REG_READ_TIME: prdata = {24'd0, codes_q.read_time};
			acfp_pkg::REG_SYS_RESET: prdata = {24'd0, codes_q.sys_reset};
			default: prdata = '0;
		endcase
	end

endmodule

// ===== hdl/acfp_parse_core.sv =====
// Frame state registers and the per-byte update and result logic.
module acfp_parse_core (
	input  logic clk,
	input  logic arst_n,
	input  logic step_en,
	input  logic [7:0] rx_byte,
	input  acfp_pkg::codes_t codes,
	output acfp_pkg::result_t result
);

	logic [2:0] phase_q, phase_d;
	logic [7:0] cmd_q, cmd_d;
	logic [7:0] len_q, len_d;
	logic [7:0] left_q, left_d;
	logic [15:0] sum_q, sum_d;
	logic [31:0] acc_q, acc_d;
	logic [7:0] first_q, first_d;

	logic [7:0] len_in;
	logic take_len;
	logic [15:0] sum_base;
	logic [7:0] digit;
	logic [7:0] left_dec;
	logic [15:0] chk;
	logic [7:0] echo;
	logic done;

	assign digit = rx_byte - acfp_pkg::ASCII_ZERO;
	assign left_dec = left_q - 8'd1;
	assign chk = ({8'd0, first_q} - {8'd0, acfp_pkg::ASCII_ZERO}) * 16'd10
		+ ({8'd0, rx_byte} - {8'd0, acfp_pkg::ASCII_ZERO});

	always_comb begin
		phase_d = phase_q;
		cmd_d = cmd_q;
		len_d = len_q;
		left_d = left_q;
		sum_d = sum_q;
		acc_d = acc_q;
		first_d = first_q;
		take_len = 1'b0;
		len_in = rx_byte;
		sum_base = sum_q;
		echo = rx_byte;
		done = 1'b0;
		unique case (phase_q)
			acfp_pkg::PH_LEN: begin
				take_len = 1'b1;
			end
			acfp_pkg::PH_DATA: begin
				sum_d = sum_q + {8'd0, digit};
				acc_d = {acc_q[28:0], 3'd0} + {acc_q[30:0], 1'b0} + {24'd0, digit};
				left_d = left_dec;
				if (left_dec == 8'd0) begin
					phase_d = acfp_pkg::PH_CK1;
				end
			end
			acfp_pkg::PH_CK1: begin
				first_d = rx_byte;
				phase_d = acfp_pkg::PH_CK2;
			end
			acfp_pkg::PH_CK2: begin
				echo = chk[7:0] + acfp_pkg::ASCII_ZERO;
				done = 1'b1;
				phase_d = acfp_pkg::PH_CMD;
			end
			default: begin
				cmd_d = rx_byte;
				acc_d = '0;
				sum_base = {8'd0, rx_byte} - {8'd0, acfp_pkg::ASCII_ZERO};
				sum_d = sum_base;
				phase_d = acfp_pkg::PH_LEN;
				if (rx_byte == codes.light_on || rx_byte == codes.light_off
						|| rx_byte == codes.set_color) begin
					take_len = 1'b1;
					len_in = acfp_pkg::ASCII_ONE;
				end else if (rx_byte == codes.read_time || rx_byte == codes.sys_reset) begin
					take_len = 1'b1;
					len_in = acfp_pkg::ASCII_ZERO;
				end
			end
		endcase
		if (take_len) begin
			len_d = len_in;
			sum_d = sum_base + ({8'd0, len_in} - {8'd0, acfp_pkg::ASCII_ZERO});
			left_d = (len_in >= acfp_pkg::ASCII_ZERO) ? len_in - acfp_pkg::ASCII_ZERO : 8'd0;
			phase_d = (left_d != 8'd0) ? acfp_pkg::PH_DATA : acfp_pkg::PH_CK1;
		end
	end

	always_comb begin
		result = '0;
		result.echo_byte = echo;
		if (done) begin
			result.frame_done = 1'b1;
			result.checksum_ok = (chk == sum_q);
			result.command_code = cmd_q;
			result.data_count = (len_q >= acfp_pkg::ASCII_ZERO) ?
				len_q - acfp_pkg::ASCII_ZERO : 8'd0;
			result.decimal_value = acc_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= acfp_pkg::PH_CMD;
		end else if (step_en) begin
			phase_q <= phase_d;
		end
	end

	always_ff @(posedge clk) begin
		if (step_en) begin
			cmd_q <= cmd_d;
			len_q <= len_d;
			left_q <= left_d;
			sum_q <= sum_d;
			acc_q <= acc_d;
			first_q <= first_d;
		end
	end

endmodule

// ===== bench/tb_ascii_command_frame_parser_top.sv =====
// Self-checking testbench for the ASCII command frame parser: random frames, stalls, codes.
`timescale 1ns / 100ps

module tb_ascii_command_frame_parser_top;

	localparam int ClkHalf = 6;
	localparam int StallLimit = 2000;

	typedef enum int {
		DATA_DIGITS,
		DATA_ANY,
		DATA_NINES,
		DATA_EXTREMES
	} data_kind_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [acfp_pkg::AddrWidth-1:0] paddr = '0;
	logic [acfp_pkg::DataWidth-1:0] pwdata = '0;
	logic [acfp_pkg::DataWidth-1:0] prdata;
	logic pready;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [7:0] rx_byte = 8'h00;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [7:0] echo_byte;
	logic frame_done;
	logic checksum_ok;
	logic [7:0] command_code;
	logic [7:0] data_count;
	logic [31:0] decimal_value;

	// Frame tracker state, mirroring the block.
	acfp_pkg::codes_t codes = '{acfp_pkg::RST_LIGHT_ON, acfp_pkg::RST_LIGHT_OFF,
		acfp_pkg::RST_SET_COLOR, acfp_pkg::RST_READ_TIME, acfp_pkg::RST_SYS_RESET};
	logic [2:0] frame_ph = acfp_pkg::PH_CMD;
	logic [7:0] frame_cmd = 8'h00;
	logic [7:0] frame_len = 8'h00;
	logic [7:0] digits_rem = 8'h00;
	logic [15:0] sum_acc = 16'h0000;
	logic [31:0] value_acc = 32'h0;
	logic [7:0] check_hi = 8'h00;

	logic [7:0] rx_backlog[$];
	acfp_pkg::result_t frame_results[$];
	bit in_taken = 1'b0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int idle_cycles = 0;
	int errors = 0;

	ascii_command_frame_parser_top u_top (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.echo_byte(echo_byte),
		.frame_done(frame_done),
		.checksum_ok(checksum_ok),
		.command_code(command_code),
		.data_count(data_count),
		.decimal_value(decimal_value)
	);

	always #(ClkHalf) clk = ~clk;

	task automatic take_length(input logic [7:0] len);
		frame_len = len;
		sum_acc = sum_acc + ({8'd0, len} - 16'h0030);
		digits_rem = (len >= acfp_pkg::ASCII_ZERO) ? len - acfp_pkg::ASCII_ZERO : 8'd0;
		frame_ph = (digits_rem != 8'd0) ? acfp_pkg::PH_DATA : acfp_pkg::PH_CK1;
	endtask

	task automatic parse_rx_byte(input logic [7:0] rx);
		acfp_pkg::result_t r;
		logic [7:0] d;
		logic [15:0] chk;
		r = '0;
		r.echo_byte = rx;
		unique case (frame_ph)
			acfp_pkg::PH_LEN: take_length(rx);
			acfp_pkg::PH_DATA: begin
				d = rx - acfp_pkg::ASCII_ZERO;
				sum_acc = sum_acc + {8'd0, d};
				value_acc = value_acc * 32'd10 + {24'd0, d};
				digits_rem = digits_rem - 8'd1;
				if (digits_rem == 8'd0)
					frame_ph = acfp_pkg::PH_CK1;
			end
			acfp_pkg::PH_CK1: begin
				check_hi = rx;
				frame_ph = acfp_pkg::PH_CK2;
			end
			acfp_pkg::PH_CK2: begin
				chk = ({8'd0, check_hi} - 16'h0030) * 16'd10 + ({8'd0, rx} - 16'h0030);
				r.echo_byte = chk[7:0] + acfp_pkg::ASCII_ZERO;
				r.checksum_ok = (chk == sum_acc);
				r.frame_done = 1'b1;
				r.command_code = frame_cmd;
				r.data_count = (frame_len >= acfp_pkg::ASCII_ZERO) ?
					frame_len - acfp_pkg::ASCII_ZERO : 8'd0;
				r.decimal_value = value_acc;
				frame_ph = acfp_pkg::PH_CMD;
			end
			default: begin
				frame_cmd = rx;
				value_acc = 32'h0;
				sum_acc = {8'd0, rx} - 16'h0030;
				if (rx == codes.light_on || rx == codes.light_off || rx == codes.set_color)
					take_length(acfp_pkg::ASCII_ONE);
				else if (rx == codes.read_time || rx == codes.sys_reset)
					take_length(acfp_pkg::ASCII_ZERO);
				else
					frame_ph = acfp_pkg::PH_LEN;
			end
		endcase
		frame_results.push_back(r);
	endtask

	task automatic compare_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, actual %0h", name, want, got);
			errors++;
		end
	endtask

	task automatic check_result();
		acfp_pkg::result_t want;
		if (frame_results.size() == 0) begin
			$error("echo_byte: expected nothing, actual %0h", echo_byte);
			errors++;
		end else begin
			want = frame_results.pop_front();
			compare_field("echo_byte", 32'(want.echo_byte), 32'(echo_byte));
			compare_field("frame_done", 32'(want.frame_done), 32'(frame_done));
			compare_field("checksum_ok", 32'(want.checksum_ok), 32'(checksum_ok));
			compare_field("command_code", 32'(want.command_code), 32'(command_code));
			compare_field("data_count", 32'(want.data_count), 32'(data_count));
			compare_field("decimal_value", want.decimal_value, decimal_value);
		end
	endtask

	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			out_ready <= 1'b0;
		end else begin
			if (!in_valid || in_taken) begin
				in_taken = 1'b0;
				if (rx_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					rx_byte <= rx_backlog.pop_front();
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
			out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				parse_rx_byte(rx_byte);
				in_taken = 1'b1;
			end
			if (out_valid && out_ready)
				check_result();
			if ((in_valid && in_ready) || (out_valid && out_ready) ||
					(rx_backlog.size() == 0 && !in_valid && frame_results.size() == 0)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
				if (idle_cycles >= StallLimit) begin
					$display("FAILURE");
					$finish;
				end
			end
		end
	end

	task automatic write_code(input logic [2:0] idx, input logic [7:0] val);
		logic [31:0] w;
		w = $urandom;
		w[7:0] = val;
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= w;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		unique case (idx)
			acfp_pkg::REG_LIGHT_ON: codes.light_on = val;
			acfp_pkg::REG_LIGHT_OFF: codes.light_off = val;
			acfp_pkg::REG_SET_COLOR: codes.set_color = val;
			acfp_pkg::REG_READ_TIME: codes.read_time = val;
			acfp_pkg::REG_SYS_RESET: codes.sys_reset = val;
			default: ;
		endcase
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic set_codes(input logic [7:0] lon, input logic [7:0] loff, input logic [7:0] col,
			input logic [7:0] rtime, input logic [7:0] sreset);
		write_code(acfp_pkg::REG_LIGHT_ON, lon);
		write_code(acfp_pkg::REG_LIGHT_OFF, loff);
		write_code(acfp_pkg::REG_SET_COLOR, col);
		write_code(acfp_pkg::REG_READ_TIME, rtime);
		write_code(acfp_pkg::REG_SYS_RESET, sreset);
	endtask

	task automatic add_frame(input logic [7:0] cmd, input logic [7:0] len, input data_kind_t kind,
			input bit good);
		logic [15:0] s;
		logic [7:0] eff_len;
		logic [7:0] d;
		logic [7:0] dv;
		int n;
		int i;
		int sv;
		int q;
		int r;
		rx_backlog.push_back(cmd);
		s = {8'd0, cmd} - 16'h0030;
		if (cmd == codes.light_on || cmd == codes.light_off || cmd == codes.set_color) begin
			eff_len = acfp_pkg::ASCII_ONE;
		end else if (cmd == codes.read_time || cmd == codes.sys_reset) begin
			eff_len = acfp_pkg::ASCII_ZERO;
		end else begin
			eff_len = len;
			rx_backlog.push_back(len);
		end
		s = s + ({8'd0, eff_len} - 16'h0030);
		n = (eff_len >= acfp_pkg::ASCII_ZERO) ?
			int'(eff_len) - int'(acfp_pkg::ASCII_ZERO) : 0;
		for (i = 0; i < n; i++) begin
			unique case (kind)
				DATA_DIGITS: d = acfp_pkg::ASCII_ZERO + 8'($urandom_range(0, 9));
				DATA_ANY: d = 8'($urandom_range(0, 255));
				DATA_NINES: d = 8'h39;
				default: d = (i % 2 != 0) ? 8'hFF : 8'h00;
			endcase
			dv = d - acfp_pkg::ASCII_ZERO;
			s = s + {8'd0, dv};
			rx_backlog.push_back(d);
		end
		// A negative sum has to be reached through the wrap of the two-digit checksum.
		sv = (s > 16'h7FFF) ? int'(s) - 65536 : int'(s);
		q = sv / 10;
		r = sv % 10;
		if (r < 0) begin
			q = q - 1;
			r = r + 10;
		end
		if (good && q >= -48 && q <= 207) begin
			rx_backlog.push_back(8'(48 + q));
			rx_backlog.push_back(8'(48 + r));
		end else begin
			rx_backlog.push_back(8'($urandom_range(0, 255)));
			rx_backlog.push_back(8'($urandom_range(0, 255)));
		end
	endtask

	task automatic add_random_frame();
		int pick;
		logic [7:0] cmd;
		logic [7:0] len;
		data_kind_t kind;
		if ($urandom_range(0, 99) < 8)
			repeat ($urandom_range(1, 3)) rx_backlog.push_back(8'($urandom_range(0, 255)));
		pick = $urandom_range(0, 99);
		if (pick < 40) begin
			case ($urandom_range(0, 4))
				0: cmd = codes.light_on;
				1: cmd = codes.light_off;
				2: cmd = codes.set_color;
				3: cmd = codes.read_time;
				default: cmd = codes.sys_reset;
			endcase
		end else if (pick < 70) begin
			cmd = acfp_pkg::ASCII_ZERO + 8'($urandom_range(0, 9));
		end else begin
			cmd = 8'($urandom_range(0, 255));
		end
		pick = $urandom_range(0, 99);
		if (pick < 75)
			len = acfp_pkg::ASCII_ZERO + 8'($urandom_range(0, 5));
		else if (pick < 90)
			len = 8'h36 + 8'($urandom_range(0, 14));
		else
			len = 8'($urandom_range(0, 47));
		pick = $urandom_range(0, 99);
		if (pick < 80)
			kind = DATA_DIGITS;
		else if (pick < 92)
			kind = DATA_ANY;
		else
			kind = DATA_NINES;
		add_frame(cmd, len, kind, $urandom_range(0, 99) < 80);
	endtask

	task automatic add_random_frames(input int count);
		int start;
		start = rx_backlog.size();
		while (rx_backlog.size() - start < count)
			add_random_frame();
	endtask

	task automatic wait_drained();
		do @(negedge clk); while (rx_backlog.size() != 0 || in_valid || frame_results.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		send_idle_pct = 31;
		recv_idle_pct = 71;
		set_codes(acfp_pkg::RST_LIGHT_ON, acfp_pkg::RST_LIGHT_OFF, acfp_pkg::RST_SET_COLOR,
			acfp_pkg::RST_READ_TIME, acfp_pkg::RST_SYS_RESET);
		add_frame(acfp_pkg::RST_LIGHT_ON, 8'h00, DATA_DIGITS, 1'b1);
		add_frame(acfp_pkg::RST_LIGHT_OFF, 8'h00, DATA_NINES, 1'b1);
		add_frame(acfp_pkg::RST_SET_COLOR, 8'h00, DATA_DIGITS, 1'b0);
		add_frame(acfp_pkg::RST_READ_TIME, 8'h00, DATA_DIGITS, 1'b1);
		add_frame(acfp_pkg::RST_SYS_RESET, 8'h00, DATA_DIGITS, 1'b1);
		add_frame(8'hFF, 8'h00, DATA_DIGITS, 1'b1);
		add_frame(8'h00, 8'h32, DATA_EXTREMES, 1'b0);
		add_random_frames(110);
		wait_drained();

		set_codes(8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
		add_random_frames(110);
		wait_drained();

		send_idle_pct = 71;
		recv_idle_pct = 31;
		set_codes(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
		add_frame(8'h00, 8'hFF, DATA_DIGITS, 1'b1);
		add_random_frames(60);
		wait_drained();

		set_codes(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
			8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
			8'($urandom_range(0, 255)));
		add_random_frames(110);
		wait_drained();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		set_codes(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
			8'($urandom_range(0, 255)), codes.light_on, codes.light_off);
		add_random_frames(110);
		wait_drained();

		set_codes(acfp_pkg::RST_LIGHT_ON, acfp_pkg::RST_LIGHT_OFF, acfp_pkg::RST_SET_COLOR,
			acfp_pkg::RST_READ_TIME, acfp_pkg::RST_SYS_RESET);
		add_random_frames(110);
		wait_drained();

		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// ===== sim.f =====
hdl/acfp_pkg.sv
hdl/acfp_cfg_regs.sv
hdl/acfp_parse_core.sv
hdl/ascii_command_frame_parser_top.sv
bench/tb_ascii_command_frame_parser_top.sv
